// ----- src/assert_macros.svh -----
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition must hold on every clock edge outside reset
`define PCS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define PCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PCS_ASSERT(label, cond, msg)
`define PCS_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

// ----- src/pcs_pkg.sv -----
// shared types and constants of the periodic command scheduler
package pcs_pkg;

  localparam int CMD_W  = 8;
  localparam int PER_W  = 10;
  localparam int POS_W  = 10;
  localparam int FREQ_W = 16;
  localparam int REQ_W  = 2;

  localparam logic [PER_W-1:0] RATE_BASE = 10'd1000;

  // frequency / 1000 by reciprocal multiply: (f * RATE_RECIP) >> RECIP_SH, exact for 16 bits
  localparam int                 RECIP_W    = 17;
  localparam logic [RECIP_W-1:0] RATE_RECIP = 17'd67109;
  localparam int                 RECIP_SH   = 26;
  localparam int                 FQ_W       = 7;

  // results per tick are capped
  localparam int RESULT_LIMIT = 16;
  localparam int N_W          = $clog2(RESULT_LIMIT + 1);

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // result kinds
  localparam logic KIND_DUE    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO_REM = 2'd2
  } status_t;

  // contents of one table cell
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [PER_W-1:0] per;
    logic [PER_W-1:0] rem;
  } cell_data_t;

  // broadcast control to the row of cells
  typedef struct packed {
    logic             load;
    logic             rotate;
    logic             mod_clr;
    logic             mod_step;
    logic             mod_bit;
    logic [CMD_W-1:0] cmd;
    logic [PER_W-1:0] per;
  } cell_ctrl_t;

endpackage

// ----- src/pcs_div.sv -----
// restoring divider, one quotient bit per cycle
module pcs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pcs_pkg::FREQ_W-1:0] dividend,
  input  logic [pcs_pkg::PER_W-1:0]  divisor,
  output logic                      done,
  output logic [pcs_pkg::FREQ_W-1:0] quotient
);
  import pcs_pkg::*;

  localparam int CNT_W = $clog2(FREQ_W + 1);

  logic [FREQ_W-1:0] q_r, q_nxt;
  logic [PER_W-1:0]  r_r, r_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [PER_W:0]    trial;
  logic [PER_W:0]    diff;

  // one shift and trial subtract per cycle
  always_comb begin
    trial    = {r_r, q_r[FREQ_W-1]};
    diff     = trial - {1'b0, divisor};
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      r_nxt   = '0;
      cnt_nxt = CNT_W'(FREQ_W);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, divisor}) begin
        r_nxt = diff[PER_W-1:0];
        q_nxt = {q_r[FREQ_W-2:0], 1'b1};
      end else begin
        r_nxt = trial[PER_W-1:0];
        q_nxt = {q_r[FREQ_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- src/pcs_cell.sv -----
// one table cell: holds an entry, reduces the position by its period, rotates
module pcs_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  pcs_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    load_addr,
  input  pcs_pkg::cell_data_t nb_in,
  output pcs_pkg::cell_data_t cell_out,
  output logic                due
);
  import pcs_pkg::*;

  cell_data_t     data_r, data_nxt;
  logic [PER_W:0] trial;
  logic [PER_W:0] diff;

  // load, remainder step or hand-over from the neighbor
  always_comb begin
    trial    = {data_r.rem, ctrl.mod_bit};
    diff     = trial - {1'b0, data_r.per};
    data_nxt = data_r;
    if (ctrl.load && (load_addr == IDX_W'(IDX))) begin
      data_nxt.cmd = ctrl.cmd;
      data_nxt.per = ctrl.per;
    end else if (ctrl.mod_clr) begin
      data_nxt.rem = '0;
    end else if (ctrl.mod_step) begin
      if (trial >= {1'b0, data_r.per}) begin
        data_nxt.rem = diff[PER_W-1:0];
      end else begin
        data_nxt.rem = trial[PER_W-1:0];
      end
    end else if (ctrl.rotate) begin
      data_nxt = nb_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // a zero period always counts as due
  assign due      = (data_r.per == '0) || (data_r.rem == '0);
  assign cell_out = data_r;

endmodule

// ----- src/periodic_command_scheduler.sv -----
// periodic command scheduler: a row of entry cells walked by one controller
// add: status after the remainder and the bit-serial 1000 / remainder, no divide if rejected
// tick: parallel remainder steps over the position bits, then rotation through all MAX_ENTRIES
//   cells, one entry a cycle while the output is free, then a flush state
// clear: straight to the status response; one item at a time, in_tready high only when idle
// reset (rst_n, synchronous, low) empties the table and sets the position to 0
module periodic_command_scheduler #(
  parameter int MAX_ENTRIES = 16,
  parameter int TICK_WRAP   = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command_id[7:0], frequency[23:8]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // due_command[7:0], position[17:8], status[19:18], zero
  output logic        out_tuser,  // result_kind[0]
  output logic        out_tlast
);
  import pcs_pkg::*;

`include "assert_macros.svh"

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int BIT_W  = $clog2(POS_W);
  localparam int PROD_W = FREQ_W + RECIP_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV1  = 7'b0000010,
    S_DIV2  = 7'b0000100,
    S_MOD   = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt, pos_inc;
  logic [CNT_W-1:0]  walk_r, walk_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [CMD_W-1:0]  pend_cmd_r, pend_cmd_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [PER_W-1:0]  divisor_r, divisor_nxt;
  status_t           status_r, status_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [FQ_W-1:0]   freq_quot_r, freq_quot_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [CMD_W-1:0]  out_cmd_r, out_cmd_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_xfer, out_free;
  logic [REQ_W-1:0]  in_req;
  logic [CMD_W-1:0]  in_cmd;
  logic [FREQ_W-1:0] in_freq;

  logic [PROD_W-1:0] freq_prod;
  logic [FREQ_W-1:0] freq_rem_wide;
  logic [PER_W-1:0]  freq_rem;

  logic              div_start, div_done;
  logic [FREQ_W-1:0] div_quot;

  cell_ctrl_t        ctrl;
  cell_data_t        cell_q [MAX_ENTRIES];
  logic              cell_due [MAX_ENTRIES];

  assign in_req    = in_tuser;
  assign in_cmd    = in_tdata[7:0];
  assign in_freq   = in_tdata[23:8];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign pos_inc = (pos_r == POS_W'(TICK_WRAP - 1)) ? '0 : pos_r + 1'b1;

  // freq mod 1000: quotient by reciprocal multiply at the transfer, remainder in the cycle after
  assign freq_prod     = PROD_W'(in_freq) * PROD_W'(RATE_RECIP);
  assign freq_rem_wide = freq_r - FREQ_W'(freq_quot_r) * FREQ_W'(RATE_BASE);
  assign freq_rem      = freq_rem_wide[PER_W-1:0];

  // shared divider: 1000 / remainder
  pcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (FREQ_W'(RATE_BASE)),
    .divisor  (divisor_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // row of cells, each handing its entry to the one below when rotating
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    pcs_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_addr (count_r[IDX_W-1:0]),
      .nb_in     (cell_q[(i + 1) % MAX_ENTRIES]),
      .cell_out  (cell_q[i]),
      .due       (cell_due[i])
    );
  end

  // controller
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    walk_nxt       = walk_r;
    bit_nxt        = bit_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_cmd_nxt   = pend_cmd_r;
    cmd_nxt        = cmd_r;
    divisor_nxt    = divisor_r;
    status_nxt     = status_r;
    freq_nxt       = freq_r;
    freq_quot_nxt  = freq_quot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_cmd_nxt    = out_cmd_r;
    out_pos_nxt    = out_pos_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    div_start      = 1'b0;
    ctrl           = '0;
    ctrl.mod_bit   = pos_r[bit_r];
    ctrl.cmd       = cmd_r;
    ctrl.per       = div_quot[PER_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_req)
            REQ_TICK: begin
              ctrl.mod_clr = 1'b1;
              bit_nxt      = BIT_W'(POS_W - 1);
              state_nxt    = S_MOD;
            end
            REQ_ADD: begin
              cmd_nxt       = in_cmd;
              freq_nxt      = in_freq;
              freq_quot_nxt = freq_prod[RECIP_SH +: FQ_W];
              state_nxt     = S_DIV1;
            end
            REQ_CLEAR: begin
              count_nxt  = '0;
              pos_nxt    = '0;
              status_nxt = ST_OK;
              state_nxt  = S_RESP;
            end
            default: ;
          endcase
        end
      end

      // remainder check first, then the full check, then start 1000 / remainder
      S_DIV1: begin
        if (freq_rem == '0) begin
          status_nxt = ST_ZERO_REM;
          state_nxt  = S_RESP;
        end else if (count_r == CNT_W'(MAX_ENTRIES)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          divisor_nxt = freq_rem;
          div_start   = 1'b1;
          state_nxt   = S_DIV2;
        end
      end

      S_DIV2: begin
        if (div_done) begin
          ctrl.load  = 1'b1;
          count_nxt  = count_r + 1'b1;
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
        end
      end

      S_MOD: begin
        ctrl.mod_step = 1'b1;
        bit_nxt       = bit_r - 1'b1;
        if (bit_r == '0) begin
          walk_nxt       = '0;
          n_nxt          = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_WALK;
        end
      end

      // entry walk_r sits in cell 0; a found entry waits in pend until the next is found or the flush
      S_WALK: begin
        if (out_free) begin
          ctrl.rotate = 1'b1;
          if ((walk_r < count_r) && cell_due[0] && (n_r < N_W'(RESULT_LIMIT))) begin
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_DUE;
              out_cmd_nxt    = pend_cmd_r;
              out_pos_nxt    = pos_r;
              out_status_nxt = ST_OK;
              out_last_nxt   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_cmd_nxt   = cell_q[0].cmd;
            n_nxt          = n_r + 1'b1;
          end
          walk_nxt = walk_r + 1'b1;
          if (walk_r == CNT_W'(MAX_ENTRIES - 1)) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid_r) begin
          pos_nxt   = pos_inc;
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_DUE;
          out_cmd_nxt    = pend_cmd_r;
          out_pos_nxt    = pos_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          pos_nxt        = pos_inc;
          state_nxt      = S_IDLE;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_cmd_nxt    = '0;
          out_pos_nxt    = '0;
          out_status_nxt = status_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    bit_r        <= bit_nxt;
    n_r          <= n_nxt;
    pend_cmd_r   <= pend_cmd_nxt;
    cmd_r        <= cmd_nxt;
    divisor_r    <= divisor_nxt;
    status_r     <= status_nxt;
    freq_r       <= freq_nxt;
    freq_quot_r  <= freq_quot_nxt;
    out_kind_r   <= out_kind_nxt;
    out_cmd_r    <= out_cmd_nxt;
    out_pos_r    <= out_pos_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pos_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pos_r        <= pos_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result transfer
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_status_r, out_pos_r, out_cmd_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // checks
  `PCS_ASSERT(a_count_range, count_r <= CNT_W'(MAX_ENTRIES), "entry count past table size")
  `PCS_ASSERT(a_pos_range, pos_r < POS_W'(TICK_WRAP), "tick position past wrap")
  `PCS_ASSERT_IMP(a_pend_scope, pend_valid_r, (state_r == S_WALK) || (state_r == S_FLUSH), "pending result outside a tick walk")
  `PCS_ASSERT_IMP(a_limit, state_r == S_WALK, n_r <= N_W'(RESULT_LIMIT), "result count past limit")
  `PCS_ASSERT_IMP(a_rem_range, state_r == S_DIV1, freq_rem_wide < FREQ_W'(RATE_BASE), "bad freq remainder")

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the periodic command scheduler
`timescale 1ns / 1ps

module tb;
  import pcs_pkg::*;

  localparam int MAX_ENTRIES  = 16;
  localparam int TICK_WRAP    = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIRECTED   = 26;

  // request code that the block ignores
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SILENT,
    CHK_STATUS
  } row_check_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [CMD_W-1:0]  cmd;
    logic [FREQ_W-1:0] freq;
    row_check_t        chk;
    status_t           st;
  } stim_row_t;

  // one result transfer, split into its fields
  typedef struct packed {
    logic             kind;
    logic [3:0]       pad;
    status_t          st;
    logic [POS_W-1:0] pos;
    logic [CMD_W-1:0] cmd;
    logic             last;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // command_id[7:0], frequency[23:8]
  logic [1:0]  in_tuser = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // due_command[7:0], position[17:8], status[19:18], zero
  logic        out_tuser;       // result_kind[0]
  logic        out_tlast;

  // scheduler state as the testbench sees it
  logic [CMD_W-1:0] slot_cmd [MAX_ENTRIES];
  int               slot_period [MAX_ENTRIES];
  int               slot_count;
  int               tick_at;
  sched_result_t    answers_due [$];

  stim_row_t     dir_rows [N_DIRECTED];
  sched_result_t seen;
  sched_result_t wanted;
  int            errors = 0;
  int            quiet = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_cnt = 0;
  bit            hold_start = 1'b0;
  bit            hold_done = 1'b0;

  periodic_command_scheduler #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .TICK_WRAP  (TICK_WRAP)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic string show(input sched_result_t r);
    return $sformatf("kind=%0d cmd=%02h pos=%0d st=%0d pad=%0h last=%0d",
                     r.kind, r.cmd, r.pos, r.st, r.pad, r.last);
  endfunction

  // advance the scheduler state by one request and, if record is set, queue the answers it causes
  function automatic void apply_request(input logic [REQ_W-1:0] req,
                                        input logic [CMD_W-1:0] cmd,
                                        input logic [FREQ_W-1:0] freq,
                                        input bit record);
    sched_result_t batch [$];
    sched_result_t r;
    int            rem;
    status_t       st;
    case (req)
      REQ_TICK: begin
        for (int i = 0; i < slot_count; i++) begin
          if ((slot_period[i] == 0 || tick_at % slot_period[i] == 0) &&
              batch.size() < RESULT_LIMIT) begin
            batch.push_back('{KIND_DUE, 4'd0, ST_OK, POS_W'(tick_at), slot_cmd[i], 1'b0});
          end
        end
        tick_at = (tick_at + 1 >= TICK_WRAP) ? 0 : tick_at + 1;
      end
      REQ_ADD: begin
        rem = int'(freq) % int'(RATE_BASE);
        // remainder check comes before the full check
        if (rem == 0) begin
          st = ST_ZERO_REM;
        end else if (slot_count >= MAX_ENTRIES) begin
          st = ST_FULL;
        end else begin
          slot_cmd[slot_count]    = cmd;
          slot_period[slot_count] = int'(RATE_BASE) / rem;
          slot_count++;
          st = ST_OK;
        end
        batch.push_back('{KIND_STATUS, 4'd0, st, POS_W'(0), CMD_W'(0), 1'b1});
      end
      REQ_CLEAR: begin
        slot_count = 0;
        tick_at    = 0;
        batch.push_back('{KIND_STATUS, 4'd0, ST_OK, POS_W'(0), CMD_W'(0), 1'b1});
      end
      default: begin
      end
    endcase
    if (record) begin
      foreach (batch[k]) begin
        r = batch[k];
        if (k == batch.size() - 1) r.last = 1'b1;
        answers_due.push_back(r);
      end
    end
  endfunction

  // offer one request and wait for its transfer
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [CMD_W-1:0] cmd,
                              input logic [FREQ_W-1:0] freq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {freq, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic random_request();
    int               pick;
    int               fsel;
    logic [REQ_W-1:0] req;
    logic [CMD_W-1:0] cmd;
    logic [FREQ_W-1:0] freq;
    pick = $urandom_range(0, 99);
    fsel = $urandom_range(0, 9);
    cmd  = CMD_W'($urandom);
    // mix exact multiples of the rate base, small rates and full-range values
    if (fsel == 0) freq = FREQ_W'($urandom_range(0, 65) * 1000);
    else if (fsel < 4) freq = FREQ_W'($urandom_range(1, 999));
    else freq = FREQ_W'($urandom);
    if (pick < 52) req = REQ_TICK;
    else if (pick < 92) req = REQ_ADD;
    else if (pick < 96) req = REQ_CLEAR;
    else req = REQ_IGNORED;
    send_request(req, cmd, freq);
    apply_request(req, cmd, freq, 1'b1);
  endtask

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (hold_start && !hold_done) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare each result transfer with the oldest queued answer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = '{out_tuser, out_tdata[23:20], status_t'(out_tdata[19:18]), out_tdata[17:8],
               out_tdata[7:0], out_tlast};
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %s", $time, show(seen));
        errors++;
      end else begin
        wanted = answers_due.pop_front();
        if (seen !== wanted) begin
          $display("%0t: mismatch, expected %s, got %s", $time, show(wanted), show(seen));
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("[periodic_command_scheduler] ERROR");
        $finish;
      end
    end
  end

  initial begin
    // extremes, status codes and the ignored request
    dir_rows = '{
      '{REQ_TICK,    8'h00, 16'h0000, CHK_SILENT, ST_OK},
      '{REQ_IGNORED, 8'hFF, 16'hFFFF, CHK_SILENT, ST_OK},
      '{REQ_ADD,     8'h00, 16'h0000, CHK_STATUS, ST_ZERO_REM},
      '{REQ_ADD,     8'hFF, 16'hFFFF, CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h5A, 16'd1000, CHK_STATUS, ST_ZERO_REM},
      '{REQ_ADD,     8'hA5, 16'd1,    CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h11, 16'd999,  CHK_STATUS, ST_OK},
      '{REQ_TICK,    8'h00, 16'h0000, CHK_MODEL,  ST_OK},
      '{REQ_ADD,     8'h01, 16'd2,     CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h02, 16'd5,     CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h04, 16'd10,    CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h08, 16'd20,    CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h10, 16'd50,    CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h20, 16'd125,   CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h40, 16'd200,   CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h80, 16'd333,   CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h7F, 16'd1001,  CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h3C, 16'd65001, CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'hC3, 16'd12345, CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'hE0, 16'd32768, CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h0F, 16'd4,     CHK_STATUS, ST_OK},
      '{REQ_ADD,     8'h99, 16'h8001,  CHK_STATUS, ST_FULL},
      '{REQ_ADD,     8'h66, 16'd64000, CHK_STATUS, ST_ZERO_REM},
      '{REQ_TICK,    8'h00, 16'h0000,  CHK_MODEL,  ST_OK},
      '{REQ_CLEAR,   8'hFF, 16'hFFFF,  CHK_STATUS, ST_OK},
      '{REQ_TICK,    8'h00, 16'h0000,  CHK_SILENT, ST_OK}
    };
    slot_count = 0;
    tick_at    = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // first idling mix, with the long receiver hold-off early on
    send_idle_pct = 17;
    recv_idle_pct = 58;
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].cmd, dir_rows[i].freq);
      apply_request(dir_rows[i].req, dir_rows[i].cmd, dir_rows[i].freq,
                    dir_rows[i].chk == CHK_MODEL);
      if (dir_rows[i].chk == CHK_STATUS) begin
        answers_due.push_back('{KIND_STATUS, 4'd0, dir_rows[i].st, POS_W'(0), CMD_W'(0), 1'b1});
      end
    end
    hold_start = 1'b1;
    repeat (30) random_request();

    // swapped idling mix
    send_idle_pct = 58;
    recv_idle_pct = 17;
    repeat (30) random_request();

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (24) random_request();
    in_tvalid <= 1'b0;

    // drain, then allow the block to settle
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[periodic_command_scheduler] OK");
    end else begin
      $display("[periodic_command_scheduler] ERROR");
    end
    $finish;
  end

endmodule
